// ===== rtl/core/tlv_record_parser_macros.svh =====
// Assertion macros used by the record parser RTL.
// Files that check their own logic include this header by its bare name.
`ifndef TLV_RECORD_PARSER_MACROS_SVH
`define TLV_RECORD_PARSER_MACROS_SVH
`ifndef SYNTH
// Property checked at every clock edge outside of reset.
`define TLVP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tlvp assertion failed");
// Property checked at every clock edge, reset included.
`define TLVP_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("tlvp assertion failed");
`else
`define TLVP_ASSERT(label, clk, rst_n, prop)
`define TLVP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/core/tlvp_pkg.sv =====
// Types, codes and helper functions of the record parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package tlvp_pkg;

	// Default width in bytes of the long scalar type.
	localparam int unsigned LONG_BYTES_DEF = 8;
	// Header: one type byte and four little-endian length bytes.
	localparam int unsigned HEADER_BYTES = 5;
	localparam int unsigned LEN_BYTES = HEADER_BYTES - 1;

	// Field widths of the result item.
	localparam int unsigned TYPE_W = 8;
	localparam int unsigned LEN_W = 32;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned RES_DATA_W = TYPE_W + LEN_W + VALUE_W + BYTE_W;

	// Type codes.
	localparam logic [TYPE_W-1:0] TYPE_U8 = 8'd0;
	localparam logic [TYPE_W-1:0] TYPE_U16 = 8'd1;
	localparam logic [TYPE_W-1:0] TYPE_U32 = 8'd2;
	localparam logic [TYPE_W-1:0] TYPE_LONG = 8'd3;
	localparam logic [TYPE_W-1:0] TYPE_BYTES = 8'd4;

	// Result kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_SCALAR  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_EMPTY   = 2'd2,
		KIND_UNKNOWN = 2'd3
	} kind_t;

	// Parser phases.
	typedef enum logic [1:0] {
		PH_TYPE    = 2'd0,
		PH_LEN     = 2'd1,
		PH_SCALAR  = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	// One registered input item on its way to the parser.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} byte_item_t;

	// Width in bytes of a scalar type; the long type and anything above use long_bytes.
	function automatic logic [3:0] scalar_width(input logic [TYPE_W-1:0] t,
		input logic [3:0] long_bytes);
		logic [3:0] w;
		case (t)
			TYPE_U8: begin
				w = 4'd1;
			end
			TYPE_U16: begin
				w = 4'd2;
			end
			TYPE_U32: begin
				w = 4'd4;
			end
			default: begin
				w = long_bytes;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tlvp_in_reg.sv =====
// Input register of the record parser: holds one stream byte for the parser.
// Depends on tlvp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlvp_in_reg
	import tlvp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [BYTE_W-1:0] s_tdata,   // data_byte
	input  wire logic              take,
	output byte_item_t             item
);

	logic              valid_q;
	logic [BYTE_W-1:0] data_q;

	// The register is free when empty or when the parser takes its item now.
	assign s_tready = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	// Data register needs no reset.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_q <= s_tdata;
		end
	end

	assign item = '{valid: valid_q, data: data_q};

endmodule
`default_nettype wire

// ===== rtl/core/tlvp_parser.sv =====
// Record parser state machine and result register.
// Depends on tlvp_pkg and tlv_record_parser_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "tlv_record_parser_macros.svh"
module tlvp_parser
	import tlvp_pkg::*;
#(
	parameter int unsigned LONG_BYTES = LONG_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire byte_item_t            item,
	output logic                       take,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [RES_DATA_W-1:0]      m_tdata,   // type_code, record_length, scalar_value, payload_byte
	output logic [KIND_W-1:0]          m_tuser,   // result_kind
	output logic                       m_tlast    // last
);

	localparam logic [3:0] LONG_W = 4'(LONG_BYTES);

	phase_t              phase_q, phase_d;
	logic [LEN_W-1:0]    cnt_q, cnt_d, cnt_inc;
	logic [TYPE_W-1:0]   type_q, type_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [VALUE_W-1:0]  acc_q, acc_d;

	logic                emit;
	kind_t               kind_d;
	logic [VALUE_W-1:0]  value_d;
	logic [BYTE_W-1:0]   pbyte_d;
	logic                last_d;

	logic                res_valid_q;
	kind_t               res_kind_q;
	logic [TYPE_W-1:0]   res_type_q;
	logic [LEN_W-1:0]    res_len_q;
	logic [VALUE_W-1:0]  res_value_q;
	logic [BYTE_W-1:0]   res_pbyte_q;
	logic                res_last_q;

	logic                out_free;
	logic                fire;

	// An item is processed whenever the result register can take its result.
	assign out_free = !res_valid_q || m_tready;
	assign take = out_free;
	assign fire = item.valid && out_free;
	assign cnt_inc = cnt_q + 32'd1;

	// Phase register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
		end else if (fire) begin
			phase_q <= phase_d;
		end
	end

	// Next phase, header and value assembly, and the result of this item.
	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		type_d = type_q;
		len_d = len_q;
		acc_d = acc_q;
		emit = 1'b0;
		kind_d = KIND_SCALAR;
		value_d = '0;
		pbyte_d = '0;
		last_d = 1'b0;
		case (phase_q)
			PH_TYPE: begin
				type_d = item.data;
				len_d = '0;
				cnt_d = '0;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d = len_q | ({24'd0, item.data} << {cnt_q[1:0], 3'b000});
				cnt_d = cnt_inc;
				if (cnt_inc == 32'(LEN_BYTES)) begin
					cnt_d = '0;
					acc_d = '0;
					if (type_q <= TYPE_LONG) begin
						phase_d = PH_SCALAR;
					end else if (type_q == TYPE_BYTES) begin
						if (len_d != '0) begin
							phase_d = PH_PAYLOAD;
						end else begin
							phase_d = PH_TYPE;
							emit = 1'b1;
							kind_d = KIND_EMPTY;
							last_d = 1'b1;
						end
					end else begin
						phase_d = PH_TYPE;
						emit = 1'b1;
						kind_d = KIND_UNKNOWN;
						last_d = 1'b1;
					end
				end
			end
			PH_SCALAR: begin
				acc_d = acc_q | ({56'd0, item.data} << {cnt_q[2:0], 3'b000});
				cnt_d = cnt_inc;
				if (cnt_inc[3:0] >= scalar_width(type_q, LONG_W)) begin
					phase_d = PH_TYPE;
					cnt_d = '0;
					emit = 1'b1;
					kind_d = KIND_SCALAR;
					value_d = acc_d;
					last_d = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				cnt_d = cnt_inc;
				emit = 1'b1;
				kind_d = KIND_PAYLOAD;
				pbyte_d = item.data;
				if (cnt_inc >= len_q) begin
					phase_d = PH_TYPE;
					cnt_d = '0;
					last_d = 1'b1;
				end
			end
			default: begin
				phase_d = PH_TYPE;
			end
		endcase
	end

	// Counter and record registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			type_q <= '0;
			len_q <= '0;
			acc_q <= '0;
		end else if (fire) begin
			cnt_q <= cnt_d;
			type_q <= type_d;
			len_q <= len_d;
			acc_q <= acc_d;
		end
	end

	// Result valid flag: set by an item that yields a result, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= fire && emit;
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_kind_q <= kind_d;
			res_type_q <= type_d;
			res_len_q <= len_d;
			res_value_q <= value_d;
			res_pbyte_q <= pbyte_d;
			res_last_q <= last_d;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tuser = res_kind_q;
	assign m_tdata = {res_pbyte_q, res_value_q, res_len_q, res_type_q};
	assign m_tlast = res_last_q;

	// Checks on the phase counter and on the results.
	`TLVP_ASSERT(a_type_cnt_clear, clk, arst_n, (phase_q == PH_TYPE) |-> (cnt_q == '0))
	`TLVP_ASSERT(a_len_cnt_range, clk, arst_n, (phase_q == PH_LEN) |-> (cnt_q < 32'(LEN_BYTES)))
	`TLVP_ASSERT(a_scalar_cnt_range, clk, arst_n,
		(phase_q == PH_SCALAR) |-> (cnt_q < 32'(LONG_BYTES)))
	`TLVP_ASSERT(a_single_result_last, clk, arst_n,
		(res_valid_q && (res_kind_q != KIND_PAYLOAD)) |-> res_last_q)
	`TLVP_ASSERT(a_value_only_scalar, clk, arst_n,
		(res_valid_q && (res_kind_q != KIND_SCALAR)) |-> (res_value_q == '0))

endmodule
`default_nettype wire

// ===== rtl/core/tlv_record_parser.sv =====
// Top level of the type-length-value record parser.
// Depends on tlvp_pkg, tlvp_in_reg and tlvp_parser.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes the encoded stream,
//   one byte per item. Records follow each other with no gap: a type byte, a
//   four-byte little-endian length, then the payload.
//   The master channel (m_tvalid, m_tready, m_tdata, m_tuser, m_tlast) gives at
//   most one result item per input byte. m_tuser holds the result kind, m_tlast
//   marks the final result of a record.
//   A byte that completes a result passes the input register, then the result
//   register, whose valid flag drives m_tvalid.
//   Throughput: one byte per cycle while results are taken, set by the
//   combinational parser update between the input and result registers.
//   When the receiver stalls, the result register holds its item and the input
//   register holds one more byte; s_tready then falls until the result is taken.
//   Bytes that yield no result still need a free result register to pass.
//   Reset (arst_n low) empties both registers and returns the parser to
//   expecting a type byte.
`timescale 1ns / 1ps
`default_nettype none
module tlv_record_parser
	import tlvp_pkg::*;
#(
	parameter int unsigned LONG_BYTES = LONG_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [BYTE_W-1:0]     s_tdata,   // data_byte
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [RES_DATA_W-1:0]      m_tdata,   // type_code, record_length, scalar_value, payload_byte
	output logic [KIND_W-1:0]          m_tuser,   // result_kind
	output logic                       m_tlast    // last
);

	byte_item_t item;
	logic       take;

	// Input register.
	tlvp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (take),
		.item     (item)
	);

	// Parser and result register.
	tlvp_parser #(
		.LONG_BYTES (LONG_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== verif/tlv_record_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the record parser: predicts each result from the accepted input bytes
// and compares it with the master channel. Depends on tlvp_pkg.
module tlv_record_checker
	import tlvp_pkg::*;
#(
	parameter int unsigned LONG_BYTES = LONG_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [BYTE_W-1:0]     s_tdata,   // data_byte
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [RES_DATA_W-1:0] m_tdata,   // type_code, record_length, scalar_value, payload_byte
	input  wire logic [KIND_W-1:0]     m_tuser,   // result_kind
	input  wire logic                  m_tlast,   // last
	output int unsigned                mismatches,
	output int unsigned                outstanding
);

	localparam int unsigned OFF_LEN = TYPE_W;
	localparam int unsigned OFF_VAL = TYPE_W + LEN_W;
	localparam int unsigned OFF_BYTE = TYPE_W + LEN_W + VALUE_W;

	typedef struct packed {
		kind_t               kind;
		logic [TYPE_W-1:0]   type_code;
		logic [LEN_W-1:0]    rec_len;
		logic [VALUE_W-1:0]  value;
		logic [BYTE_W-1:0]   pbyte;
		logic                last;
	} parse_result_t;

	// Parser state as this scoreboard sees it.
	phase_t             parse_phase;
	logic [31:0]        phase_bytes;
	logic [TYPE_W-1:0]  cur_type;
	logic [LEN_W-1:0]   cur_length;
	logic [VALUE_W-1:0] scalar_acc;

	parse_result_t pending_results[$];
	int unsigned errs = 0;

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	task automatic push_result(input kind_t kind, input logic [VALUE_W-1:0] value,
		input logic [BYTE_W-1:0] pbyte, input logic last);
		parse_result_t r;
		r.kind = kind;
		r.type_code = cur_type;
		r.rec_len = cur_length;
		r.value = value;
		r.pbyte = pbyte;
		r.last = last;
		pending_results.push_back(r);
	endtask

	// Advance the parser by one stream byte and queue the result it completes, if any.
	task automatic parse_byte(input logic [BYTE_W-1:0] b);
		logic [31:0] width;
		logic fin;
		case (parse_phase)
			PH_TYPE: begin
				cur_type = b;
				cur_length = '0;
				phase_bytes = 0;
				parse_phase = PH_LEN;
			end
			PH_LEN: begin
				cur_length = cur_length | ({24'd0, b} << (8 * phase_bytes[1:0]));
				phase_bytes = phase_bytes + 1;
				if (phase_bytes >= LEN_BYTES) begin
					phase_bytes = 0;
					scalar_acc = '0;
					if (cur_type <= TYPE_LONG) begin
						parse_phase = PH_SCALAR;
					end else if (cur_type == TYPE_BYTES && cur_length != 0) begin
						parse_phase = PH_PAYLOAD;
					end else if (cur_type == TYPE_BYTES) begin
						// A byte string with no payload ends right after its header.
						parse_phase = PH_TYPE;
						push_result(KIND_EMPTY, '0, '0, 1'b1);
					end else begin
						// Unknown type: report it and take the next byte as a new type.
						parse_phase = PH_TYPE;
						push_result(KIND_UNKNOWN, '0, '0, 1'b1);
					end
				end
			end
			PH_SCALAR: begin
				scalar_acc = scalar_acc | ({56'd0, b} << (8 * phase_bytes[2:0]));
				phase_bytes = phase_bytes + 1;
				// The width follows from the type; the length field plays no part.
				if (cur_type == TYPE_U8) begin
					width = 1;
				end else if (cur_type == TYPE_U16) begin
					width = 2;
				end else if (cur_type == TYPE_U32) begin
					width = 4;
				end else begin
					width = LONG_BYTES;
				end
				if (phase_bytes >= width) begin
					parse_phase = PH_TYPE;
					phase_bytes = 0;
					push_result(KIND_SCALAR, scalar_acc, '0, 1'b1);
				end
			end
			default: begin
				phase_bytes = phase_bytes + 1;
				fin = (phase_bytes >= cur_length);
				if (fin) begin
					parse_phase = PH_TYPE;
					phase_bytes = 0;
				end
				push_result(KIND_PAYLOAD, '0, b, fin);
			end
		endcase
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			errs++;
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	// Predict on every accepted byte, compare on every accepted result.
	always @(posedge clk or negedge arst_n) begin
		parse_result_t want;
		if (!arst_n) begin
			parse_phase = PH_TYPE;
			phase_bytes = 0;
			cur_type = '0;
			cur_length = '0;
			scalar_acc = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					errs++;
					$display("%0t ns: unexpected result, expected none, actual kind %h data %h",
						$time, m_tuser, m_tdata);
				end else begin
					want = pending_results.pop_front();
					check_field("result_kind", 64'(want.kind), 64'(m_tuser));
					check_field("type_code", 64'(want.type_code),
						64'(m_tdata[OFF_LEN-1:0]));
					check_field("record_length", 64'(want.rec_len),
						64'(m_tdata[OFF_VAL-1:OFF_LEN]));
					check_field("scalar_value", want.value, m_tdata[OFF_BYTE-1:OFF_VAL]);
					check_field("payload_byte", 64'(want.pbyte),
						64'(m_tdata[RES_DATA_W-1:OFF_BYTE]));
					check_field("last", 64'(want.last), 64'(m_tlast));
				end
			end
			outstanding <= pending_results.size();
		end
		mismatches <= errs;
	end

endmodule

// ===== verif/tb_tlv_record_parser.sv =====
`timescale 1ns / 1ps
// Testbench top for the record parser: clock, reset, byte stream stimulus and verdict.
// Depends on tlvp_pkg, tlv_record_parser and tlv_record_checker.
module tb_tlv_record_parser;
	import tlvp_pkg::*;

	localparam int unsigned LONG_W_BYTES = LONG_BYTES_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned TAIL_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [BYTE_W-1:0] s_tdata = '0;
	logic m_tready = 1'b0;
	logic s_tready;
	logic m_tvalid;
	logic [RES_DATA_W-1:0] m_tdata;   // type_code, record_length, scalar_value, payload_byte
	logic [KIND_W-1:0] m_tuser;       // result_kind
	logic m_tlast;                    // last

	int unsigned mismatches;
	int unsigned outstanding;

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_reqs = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycles = 0;

	always #10 clk = ~clk;

	tlv_record_parser #(
		.LONG_BYTES(LONG_W_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	tlv_record_checker #(
		.LONG_BYTES(LONG_W_BYTES)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one byte after a random gap and return at the edge that accepts it.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do begin
			@(posedge clk);
		end while (!s_tready);
		bytes_sent++;
	endtask

	// One record: type, little-endian length, then the body the type calls for.
	task automatic send_record(input logic [TYPE_W-1:0] t, input logic [LEN_W-1:0] len,
		input logic [VALUE_W-1:0] val);
		int unsigned n;
		int unsigned i;
		send_byte(t);
		for (i = 0; i < LEN_BYTES; i++) begin
			send_byte(len[8*i +: 8]);
		end
		if (t <= TYPE_LONG) begin
			n = (t == TYPE_U8) ? 1 : (t == TYPE_U16) ? 2 : (t == TYPE_U32) ? 4 : LONG_W_BYTES;
			for (i = 0; i < n; i++) begin
				send_byte(val[8*i +: 8]);
			end
		end else if (t == TYPE_BYTES) begin
			for (i = 0; i < len; i++) begin
				send_byte(BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	// Mostly well-formed scalars and byte strings, some unknown-type records.
	task automatic send_random_record();
		int unsigned roll;
		logic [TYPE_W-1:0] t;
		logic [LEN_W-1:0] len;
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			t = TYPE_W'($urandom_range(TYPE_U8, TYPE_LONG));
			len = ($urandom_range(0, 3) == 0) ? LEN_W'(1 << t) : LEN_W'($urandom);
			send_record(t, len, {$urandom, $urandom});
		end else if (roll < 82) begin
			roll = $urandom_range(0, 19);
			if (roll < 2) begin
				len = 0;
			end else if (roll < 3) begin
				len = $urandom_range(13, 40);
			end else begin
				len = $urandom_range(1, 12);
			end
			send_record(TYPE_BYTES, len, '0);
		end else begin
			send_record(TYPE_W'($urandom_range(TYPE_BYTES + 1, 255)), $urandom, '0);
		end
	endtask

	// Stop offering bytes and wait until every predicted result has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int unsigned ph;
		int unsigned target;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed records: field extremes, every type, empty string, unknown types.
		send_record(TYPE_U8, 32'd1, 64'h0);
		send_record(TYPE_U8, 32'hFFFF_FFFF, 64'hFF);
		send_record(TYPE_U16, 32'd2, 64'hFFFF);
		send_record(TYPE_U32, 32'd0, 64'h8000_0001);
		send_record(TYPE_LONG, 32'd8, 64'hFFFF_FFFF_FFFF_FFFF);
		send_record(TYPE_LONG, 32'h1234_5678, 64'h0);
		send_record(TYPE_BYTES, 32'd0, '0);
		send_record(TYPE_BYTES, 32'd1, '0);
		send_record(TYPE_BYTES, 32'd5, '0);
		send_record(8'd5, 32'd7, '0);
		send_record(8'hFF, 32'hFFFF_FFFF, '0);
		send_record(TYPE_BYTES, 32'd0, '0);
		wait_drained();

		// Random phases: no idling, idle sender, stalling receiver, both.
		for (ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 68 : (ph == 3) ? 16 : 0;
			stall_pct <= (ph == 2) ? 68 : (ph == 3) ? 16 : 0;
			if (ph == 0) begin
				hold_reqs <= hold_reqs + 1;
			end
			target = bytes_sent + 75;
			while (bytes_sent < target) begin
				send_random_record();
			end
			if (ph == 1) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tlvp_pkg.sv
rtl/core/tlvp_in_reg.sv
rtl/core/tlvp_parser.sv
rtl/core/tlv_record_parser.sv
verif/tlv_record_checker.sv
verif/tb_tlv_record_parser.sv
